### rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Command codes, table entry layout and the structs passed between the
// packer control, the code table and the top level.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned LEN_BITS    = 6;
  localparam int unsigned COUNT_BITS  = 4;
  localparam int unsigned SYM_BITS    = 8;
  localparam int unsigned STREAM_BITS = BYTE_BITS + WORD_BITS;
  localparam int unsigned TOTAL_BITS  = 6;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [WORD_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           cmd;
    logic [SYM_BITS-1:0]  symbol;
    logic [WORD_BITS-1:0] code_word;
    logic [LEN_BITS-1:0]  code_length;
  } req_t;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [SYM_BITS-1:0] addr;
    entry_t              wdata;
  } tbl_req_t;

  typedef struct packed {
    logic                  valid;
    logic [BYTE_BITS-1:0]  data;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } emit_t;

endpackage

### rtl/core/hcbp_table.sv
// ----------------------------------------------------------------------------
// hcbp_table: code table memory
// One entry per symbol holding a code word and its length. Single write
// port, single read port with registered read data.
// ----------------------------------------------------------------------------
module hcbp_table #(
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic               clk_i,
  input  hcbp_pkg::tbl_req_t req_i,
  output hcbp_pkg::entry_t   rd_data_o
);
  import hcbp_pkg::*;

  localparam int unsigned AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  entry_t mem_q [SYMBOL_COUNT];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer: command control and bit accumulator
// Decodes requests, drives the code table and packs code bits MSB first
// into bytes, one byte per cycle towards the output register while it is free.
// ----------------------------------------------------------------------------
module hcbp_packer #(
  parameter int unsigned SYMBOL_COUNT    = 256,
  parameter int unsigned MAX_CODE_LENGTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcbp_pkg::req_t     req_i,
  output logic               ready_o,
  output hcbp_pkg::tbl_req_t tbl_o,
  input  hcbp_pkg::entry_t   tbl_data_i,
  input  logic               out_free_i,
  output hcbp_pkg::emit_t    emit_o
);
  import hcbp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0]             state_q, state_d;
  // Pending bits are kept left-aligned; bits past the count are zero.
  logic [BYTE_BITS-1:0]   pend_q, pend_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [STREAM_BITS-1:0] stream_q, stream_d;
  logic [TOTAL_BITS-1:0]  total_q, total_d;

  logic                   accept;
  logic                   sym_ok;
  logic                   len_ok;
  logic [LEN_BITS-1:0]    len_eff;
  logic [STREAM_BITS-1:0] code_top;

  assign ready_o = (state_q == ST_IDLE);
  assign accept  = req_i.valid && ready_o;
  assign sym_ok  = ({1'b0, req_i.symbol} < 9'(SYMBOL_COUNT));
  assign len_ok  = ({1'b0, req_i.code_length} <= 7'(MAX_CODE_LENGTH)) &&
                   ({1'b0, req_i.code_length} <= 7'(WORD_BITS));

  always_comb begin
    tbl_o.wr_en      = accept && (req_i.cmd == CMD_LOAD) && sym_ok && len_ok;
    tbl_o.rd_en      = accept && (req_i.cmd == CMD_ENCODE) && sym_ok;
    tbl_o.addr       = req_i.symbol;
    tbl_o.wdata.code = req_i.code_word;
    tbl_o.wdata.len  = req_i.code_length;
  end

  // Code bits moved to the top of the stream, then placed behind the pending bits.
  assign len_eff  = (tbl_data_i.len > LEN_BITS'(WORD_BITS)) ? LEN_BITS'(WORD_BITS)
                                                             : tbl_data_i.len;
  assign code_top = {tbl_data_i.code, {BYTE_BITS{1'b0}}} << (LEN_BITS'(WORD_BITS) - len_eff);

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    count_d  = count_q;
    stream_d = stream_q;
    total_d  = total_q;
    emit_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_ENCODE: begin
              if (sym_ok) begin
                state_d = ST_LOOKUP;
              end
            end
            CMD_FLUSH: state_d = ST_FLUSH;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        stream_d = {pend_q, {WORD_BITS{1'b0}}} | (code_top >> count_q);
        total_d  = TOTAL_BITS'({2'b00, count_q} + len_eff);
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // A full byte leaves only once at least one further bit follows it.
        if (total_q > TOTAL_BITS'(BYTE_BITS)) begin
          if (out_free_i) begin
            emit_o.valid = 1'b1;
            emit_o.data  = stream_q[STREAM_BITS-1 -: BYTE_BITS];
            emit_o.count = COUNT_BITS'(BYTE_BITS);
            emit_o.last  = (total_q <= TOTAL_BITS'(2 * BYTE_BITS));
            stream_d     = stream_q << BYTE_BITS;
            total_d      = total_q - TOTAL_BITS'(BYTE_BITS);
          end
        end else begin
          pend_d  = stream_q[STREAM_BITS-1 -: BYTE_BITS];
          count_d = total_q[COUNT_BITS-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = pend_q;
          emit_o.count = count_q;
          emit_o.last  = 1'b1;
          pend_d       = '0;
          count_d      = '0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stream_q <= stream_d;
    total_q  <= total_d;
  end

endmodule

### rtl/core/huffman_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core: Huffman code table and bit packer
// Loads code table entries, packs the codes of encoded symbols into bytes
// and flushes the final partial byte.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes requests: tuser is the command (load, encode,
// flush), tdata carries symbol, code word and code length. Loads with a
// valid symbol and a length up to MAX_CODE_LENGTH write one table entry.
// An encode reads the table (registered read data), places the code behind
// the pending bits, then sends one byte per cycle while the receiver takes
// them, 0 to 4 bytes in all; a flush always sends one byte with its bit count.
// The master stream carries results; tlast marks the final result of a
// request. Results sit in an output register, so a new request is taken
// while the last result still waits; a stalled receiver holds the packer
// before its next byte. Reset clears the pending bits; table contents are
// undefined until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core #(
  parameter int unsigned MAX_CODE_LENGTH = 32,
  parameter int unsigned SYMBOL_COUNT    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], valid_bits[11:8]
  output logic        m_axis_tlast
);
  import hcbp_pkg::*;

  req_t     req;
  tbl_req_t tbl_req;
  entry_t   tbl_data;
  emit_t    emit;
  logic     out_free;

  logic                  out_valid_q;
  logic [BYTE_BITS-1:0]  out_byte_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  out_last_q;

  always_comb begin
    req.valid       = s_axis_tvalid;
    req.cmd         = s_axis_tuser;
    req.symbol      = s_axis_tdata[7:0];
    req.code_word   = s_axis_tdata[39:8];
    req.code_length = s_axis_tdata[45:40];
  end

  hcbp_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .req_i    (tbl_req),
    .rd_data_o(tbl_data)
  );

  hcbp_packer #(
    .SYMBOL_COUNT   (SYMBOL_COUNT),
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .ready_o   (s_axis_tready),
    .tbl_o     (tbl_req),
    .tbl_data_i(tbl_data),
    .out_free_i(out_free),
    .emit_o    (emit)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_byte_q  <= emit.data;
      out_count_q <= emit.count;
      out_last_q  <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_count_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### verif/huffman_code_bit_packer_core_tb.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core_tb: self-checking bench for the bit packer
// Sends load, encode and flush requests on the slave stream. A behavioral
// copy of the code table and the byte accumulator predicts every packed
// byte. The master stream is checked while the source sends in random
// bursts and the sink stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int unsigned CODE_LIMIT = 32;  // MAX_CODE_LENGTH of the instance
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 195;
  localparam int DIRECTED_ROWS = 25;
  localparam int HOLD_START    = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;

  // A request, plus an optional result that is known without the predictor.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
    logic        fixed;
    logic [7:0]  fixed_byte;
    logic [3:0]  fixed_bits;
  } request_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       last;
  } byte_result_t;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // Predictor state: code table, accumulator and the bytes still to come.
  entry_t       code_mem [256];
  bit           code_loaded [256];
  logic [7:0]   loaded_syms [$];
  logic [7:0]   acc_bits  = '0;
  logic [3:0]   acc_count = '0;
  byte_result_t expected_bytes [$];

  int errors  = 0;
  int reports = 0;
  int burst_left = 0;

  request_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'hFF, 32'h0000_0000, 6'd1,  1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h41, 32'h0000_00A5, 6'd8,  1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h10, 32'hFFFF_FFFF, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h41, 32'h0000_0000, 6'd33, 1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h41, 32'hFFFF_FFFF, 6'd63, 1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'hA5, 4'd8},
    '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h00, 4'd1},
    '{CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 8'hFF, 4'd8},
    '{CMD_LOAD,   8'h80, 32'h0000_0001, 6'd3,  1'b0, 8'h00, 4'd0},
    '{CMD_LOAD,   8'h7F, 32'h0000_002B, 6'd6,  1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h00, 4'd0},
    '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 4'd0},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h00, 4'd1}
  };

  huffman_code_bit_packer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Updates the table and accumulator for one accepted request and queues
  // the packed bytes it produces.
  function automatic void predict_packed_bytes(input request_t r);
    byte_result_t found [4];
    int n;
    int i;
    int unsigned len;
    logic [7:0] flushed;
    n = 0;
    case (r.cmd)
      CMD_LOAD: begin
        if (r.code_length <= CODE_LIMIT) begin
          code_mem[r.symbol] = '{code: r.code_word, len: r.code_length};
          if (!code_loaded[r.symbol]) loaded_syms = {loaded_syms, r.symbol};
          code_loaded[r.symbol] = 1'b1;
        end
      end
      CMD_ENCODE: begin
        len = code_mem[r.symbol].len;
        if (len > WORD_BITS) len = WORD_BITS;
        // A full accumulator goes out only once the next bit shows up.
        for (i = len; i > 0; i--) begin
          if (acc_count >= BYTE_BITS && n < 4) begin
            found[n] = '{out_byte: acc_bits, valid_bits: 4'd8, last: 1'b0};
            n++;
            acc_bits  = '0;
            acc_count = '0;
          end
          acc_bits  = {acc_bits[6:0], code_mem[r.symbol].code[i-1]};
          acc_count = acc_count + 4'd1;
        end
      end
      CMD_FLUSH: begin
        flushed   = acc_bits << (4'd8 - acc_count);
        found[0]  = '{out_byte: flushed, valid_bits: acc_count, last: 1'b0};
        n         = 1;
        acc_bits  = '0;
        acc_count = '0;
      end
      default: ;
    endcase
    if (n > 0) found[n-1].last = 1'b1;
    if (r.fixed) begin
      found[0] = '{out_byte: r.fixed_byte, valid_bits: r.fixed_bits, last: 1'b1};
      n        = 1;
    end
    for (i = 0; i < n; i++) expected_bytes = {expected_bytes, found[i]};
  endfunction

  // Mostly encodes of loaded symbols with flushes between them; loads keep
  // changing the table, and a few unused commands and overlong loads are noise.
  function automatic request_t random_request();
    request_t r;
    int pick;
    r             = '0;
    r.symbol      = 8'($urandom);
    r.code_word   = $urandom;
    r.code_length = 6'($urandom);
    pick          = $urandom_range(0, 99);
    if (pick < 55 && loaded_syms.size() != 0) begin
      r.cmd    = CMD_ENCODE;
      r.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    end else if (pick < 78) begin
      r.cmd = CMD_LOAD;
      case ($urandom_range(0, 19))
        0:       r.code_length = 6'd0;
        1:       r.code_length = 6'd32;
        2:       r.code_length = 6'($urandom_range(33, 63));
        3, 4, 5: r.code_length = 6'($urandom_range(13, 31));
        default: r.code_length = 6'($urandom_range(1, 12));
      endcase
    end else if (pick < 96) begin
      r.cmd = CMD_FLUSH;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic offer_request(input request_t r);
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {2'b00, r.code_length, r.code_word, r.symbol};
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
    predict_packed_bytes(r);
  endtask

  task automatic source_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    request_t r;
    int counted;
    bit paused;
    counted = 0;
    paused  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[k]) begin
      offer_request(directed_rows[k]);
      source_gap();
    end
    while (counted < RANDOM_ITEMS) begin
      r = random_request();
      offer_request(r);
      if (r.cmd != CMD_UNUSED && !(r.cmd == CMD_LOAD && r.code_length > CODE_LIMIT))
        counted++;
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end else begin
        source_gap();
      end
    end
    drain_results();
    if (expected_bytes.size() != 0) begin
      $display("results never received: %0d", expected_bytes.size());
      errors += expected_bytes.size();
    end
    if (errors == 0) begin
      $display("huffman_code_bit_packer_core_tb: clean");
    end else begin
      $display("huffman_code_bit_packer_core_tb: errors");
    end
    $finish;
  end

  // The sink changes its stall pattern every stretch; once it holds off long
  // enough for the packer to fill up and refuse requests.
  initial begin : sink
    int mode;
    int stretch;
    int cycles;
    cycles = 0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(5, 60);
      repeat (stretch) begin
        @(posedge clk_i);
        cycles++;
        if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_CYCLES) begin
          m_tready <= 1'b0;
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((cycles % 5) < 3);
          endcase
        end
      end
    end
  end

  // Outputs are stable at the falling edge; a result seen here with ready
  // high is taken at the next rising edge.
  always @(negedge clk_i) begin : check_results
    byte_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        if (reports < REPORT_LIMIT)
          $display("unexpected result: byte %02h bits %0d last %0b",
                   m_tdata[7:0], m_tdata[11:8], m_tlast);
        reports++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.out_byte || m_tdata[11:8] !== want.valid_bits ||
            m_tlast !== want.last) begin
          errors++;
          if (reports < REPORT_LIMIT)
            $display("mismatch: expected byte %02h bits %0d last %0b, got %02h %0d %0b",
                     want.out_byte, want.valid_bits, want.last,
                     m_tdata[7:0], m_tdata[11:8], m_tlast);
          reports++;
        end
      end
    end
  end

  initial begin : watchdog
    #400us;
    $display("huffman_code_bit_packer_core_tb: errors");
    $finish;
  end

endmodule

### files.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_table.sv
rtl/core/hcbp_packer.sv
rtl/core/huffman_code_bit_packer_core.sv
verif/huffman_code_bit_packer_core_tb.sv
